>>> rtl/c_escape_sequence_decoder_core_defines.svh
// Assertion macros used by the escape decoder core RTL.
`ifndef C_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define C_ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define CED_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("escape decoder assertion failed");
`define CED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape decoder assertion failed");
`else
`define CED_ASSERT(label, clk, rst_n, prop)
`define CED_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/ced_pkg.sv
// Types and constants of the escape sequence decoder.
`timescale 1ns / 1ps
package ced_pkg;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_BSLASH = 2'd1,
        MODE_OCT    = 2'd2,
        MODE_HEX    = 2'd3
    } t_mode;

    typedef struct packed {
        logic [7:0] out_char;
        logic       string_done;
    } t_res;

    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 2 ** FIFO_AW;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_X_LOW  = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_LOW  = 8'h61;
    localparam logic [7:0] CH_F_LOW  = 8'h66;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_B_LOW  = 8'h62;
    localparam logic [7:0] CH_N_LOW  = 8'h6E;
    localparam logic [7:0] CH_R_LOW  = 8'h72;
    localparam logic [7:0] CH_T_LOW  = 8'h74;
    localparam logic [7:0] CH_V_LOW  = 8'h76;

endpackage

>>> rtl/ced_ifs.sv
// Valid/ready channel interfaces for the escape decoder input and result items.
`timescale 1ns / 1ps
interface ced_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_string;

    modport source (output valid, output in_char, output end_of_string, input ready);
    modport sink (input valid, input in_char, input end_of_string, output ready);
endinterface

interface ced_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       string_done;

    modport source (output valid, output out_char, output string_done, input ready);
    modport sink (input valid, input out_char, input string_done, output ready);
endinterface

>>> rtl/c_escape_sequence_decoder_core.sv
// An accepted item is held in the input register, then its results go into the result queue.
// One item per cycle while the queue has room for two results; each result leaves the queue on its own.
// A four-entry result queue lets input continue while results wait to be taken.
// Reset (synchronous, active low) empties the queue and returns to normal text.
// Top level of the backslash escape decoder.
`timescale 1ns / 1ps
`include "c_escape_sequence_decoder_core_defines.svh"
module c_escape_sequence_decoder_core (
    input  logic i_clk,
    input  logic i_rst_n,
    ced_in_if.sink    i_in,
    ced_out_if.source o_out
);
    import ced_pkg::*;

    typedef logic [FIFO_AW:0] t_cnt;
    localparam t_cnt DEPTH_C = t_cnt'(FIFO_DEPTH);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_eos;

    t_mode      r_mode, n_mode;
    logic [1:0] r_digits, n_digits;
    logic [7:0] r_value, n_value;
    logic       r_upper, n_upper;

    t_res              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    t_cnt              r_count;

    logic       accept, fire, pop;
    logic [1:0] res_n;
    t_res       res0, res1;

    logic [7:0] c;
    logic       eos;
    logic       is_bslash, is_oct, is_hex, is_blank, is_x;
    logic [3:0] hex_nib;
    logic [7:0] oct_val, hex_val;
    logic [1:0] oct_digits;
    logic       plain_emit, plain_to_bslash;
    t_res       plain_item;

    assign c   = r_in_char;
    assign eos = r_in_eos;

    assign fire   = r_in_valid && (r_count <= (DEPTH_C - t_cnt'(2)));
    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_out.valid && o_out.ready;

    assign i_in.ready        = !r_in_valid || fire;
    assign o_out.valid       = (r_count != '0);
    assign o_out.out_char    = r_fifo[r_rd].out_char;
    assign o_out.string_done = r_fifo[r_rd].string_done;

    // Character classes of the byte being processed.
    always_comb begin
        is_bslash = (c == CH_BSLASH);
        is_oct    = (c >= CH_ZERO) && (c <= CH_SEVEN);
        is_x      = (c == CH_X_LOW) || (c == CH_X_UP);
        is_blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR))
                 || (c == CH_A_LOW) || (c == CH_B_LOW) || (c == CH_F_LOW)
                 || (c == CH_N_LOW) || (c == CH_R_LOW) || (c == CH_T_LOW)
                 || (c == CH_V_LOW);
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            is_hex  = 1'b1;
            hex_nib = c[3:0];
        end else if (((c >= CH_A_LOW) && (c <= CH_F_LOW))
                  || ((c >= CH_A_UP) && (c <= CH_F_UP))) begin
            is_hex  = 1'b1;
            hex_nib = c[3:0] + 4'd9;
        end else begin
            is_hex  = 1'b0;
            hex_nib = 4'd0;
        end
        oct_val    = {r_value[4:0], c[2:0]};
        hex_val    = {r_value[3:0], hex_nib};
        oct_digits = r_digits + 2'd1;

        plain_emit      = !is_bslash || eos;
        plain_to_bslash = is_bslash && !eos;
        plain_item      = is_bslash ? t_res'{out_char: CH_SPACE, string_done: 1'b1}
                                    : t_res'{out_char: c, string_done: eos};
    end

    // One step of the decoder: next state and up to two results.
    always_comb begin
        n_mode   = r_mode;
        n_digits = r_digits;
        n_value  = r_value;
        n_upper  = r_upper;
        res_n    = 2'd0;
        res0     = '{out_char: c, string_done: eos};
        res1     = plain_item;
        unique case (r_mode)
            MODE_TEXT: begin
                res0   = plain_item;
                res_n  = {1'b0, plain_emit};
                n_mode = plain_to_bslash ? MODE_BSLASH : MODE_TEXT;
            end
            MODE_BSLASH: begin
                n_mode   = MODE_TEXT;
                n_digits = 2'd0;
                n_value  = 8'd0;
                n_upper  = 1'b0;
                priority if (is_blank) begin
                    res0  = '{out_char: CH_SPACE, string_done: eos};
                    res_n = 2'd1;
                end else if (is_oct) begin
                    if (eos) begin
                        res0  = '{out_char: {5'd0, c[2:0]}, string_done: 1'b1};
                        res_n = 2'd1;
                    end else begin
                        n_mode   = MODE_OCT;
                        n_digits = 2'd1;
                        n_value  = {5'd0, c[2:0]};
                    end
                end else if (is_x) begin
                    if (eos) begin
                        res_n = 2'd1;
                    end else begin
                        n_mode  = MODE_HEX;
                        n_upper = (c == CH_X_UP);
                    end
                end else if (is_bslash || (c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
                    res0  = '{out_char: CH_BSLASH, string_done: 1'b0};
                    res1  = '{out_char: c, string_done: eos};
                    res_n = 2'd2;
                end else begin
                    res_n = 2'd1;
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    if ((oct_digits == 2'd3) || eos) begin
                        res0     = '{out_char: oct_val, string_done: eos};
                        res_n    = 2'd1;
                        n_mode   = MODE_TEXT;
                        n_digits = 2'd0;
                        n_value  = 8'd0;
                        n_upper  = 1'b0;
                    end else begin
                        n_digits = oct_digits;
                        n_value  = oct_val;
                    end
                end else begin
                    res0     = '{out_char: r_value, string_done: 1'b0};
                    res_n    = plain_emit ? 2'd2 : 2'd1;
                    n_mode   = plain_to_bslash ? MODE_BSLASH : MODE_TEXT;
                    n_digits = 2'd0;
                    n_value  = 8'd0;
                    n_upper  = 1'b0;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    if ((r_digits == 2'd1) || eos) begin
                        res0     = '{out_char: hex_val, string_done: eos};
                        res_n    = 2'd1;
                        n_mode   = MODE_TEXT;
                        n_digits = 2'd0;
                        n_value  = 8'd0;
                        n_upper  = 1'b0;
                    end else begin
                        n_digits = 2'd1;
                        n_value  = hex_val;
                    end
                end else begin
                    if (r_digits == 2'd0) begin
                        res0 = '{out_char: (r_upper ? CH_X_UP : CH_X_LOW),
                                 string_done: 1'b0};
                    end else begin
                        res0 = '{out_char: r_value, string_done: 1'b0};
                    end
                    res_n    = plain_emit ? 2'd2 : 2'd1;
                    n_mode   = plain_to_bslash ? MODE_BSLASH : MODE_TEXT;
                    n_digits = 2'd0;
                    n_value  = 8'd0;
                    n_upper  = 1'b0;
                end
            end
            default: begin
                n_mode = MODE_TEXT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_TEXT;
            r_digits   <= 2'd0;
            r_value    <= 8'd0;
            r_upper    <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !fire);
            if (fire) begin
                r_mode   <= n_mode;
                r_digits <= n_digits;
                r_value  <= n_value;
                r_upper  <= n_upper;
                r_wr     <= r_wr + FIFO_AW'(res_n);
            end
            if (pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_count <= r_count + (fire ? t_cnt'(res_n) : t_cnt'(0))
                     - (pop ? t_cnt'(1) : t_cnt'(0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_in.in_char;
            r_in_eos  <= i_in.end_of_string;
        end
        if (fire && (res_n != 2'd0)) begin
            r_fifo[r_wr] <= res0;
        end
        if (fire && (res_n == 2'd2)) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= res1;
        end
    end

    `CED_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH_C)
    `CED_ASSERT_IMPL(a_text_clean, i_clk, i_rst_n, r_mode == MODE_TEXT, (r_digits == 2'd0) && (r_value == 8'd0))
    `CED_ASSERT_IMPL(a_oct_digits, i_clk, i_rst_n, r_mode == MODE_OCT, (r_digits == 2'd1) || (r_digits == 2'd2))
    `CED_ASSERT_IMPL(a_hex_digits, i_clk, i_rst_n, r_mode == MODE_HEX, r_digits <= 2'd1)
    `CED_ASSERT_IMPL(a_count_track, i_clk, i_rst_n, $past(i_rst_n) && $past(!fire) && $past(!pop), r_count == $past(r_count))

endmodule
